// ----- rtl/twr_pkg.sv -----
package twr_pkg;

   localparam int LAT_IN_W  = 24;
   localparam int LON_IN_W  = 25;
   localparam int TILE_LAT_W = 8;
   localparam int TILE_LON_W = 9;
   localparam int SLOT_CNT  = 4;
   localparam int SLOT_W    = 2;
   localparam int ACTION_W  = 2;

   localparam logic [ACTION_W-1:0] ACT_KEPT    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_BLOCKED = 2'd2;

   // Neighbor entries 1..3 per half combination {lat_lo, lon_lo}.
   // Bit k set: entry k+1 applies the step on that axis.
   localparam logic [2:0] USE_LAT [SLOT_CNT] = '{3'b110, 3'b110, 3'b011, 3'b011};
   localparam logic [2:0] USE_LON [SLOT_CNT] = '{3'b101, 3'b011, 3'b110, 3'b101};

   typedef struct packed {
      logic [SLOT_CNT-1:0]                 valid;
      logic [SLOT_CNT-1:0][TILE_LAT_W-1:0] lat;
      logic [SLOT_CNT-1:0][TILE_LON_W-1:0] lon;
      logic [SLOT_CNT-1:0][SLOT_W-1:0]     pos;
   } twr_slots_type;

   typedef struct packed {
      logic                blocked;
      logic [SLOT_CNT-1:0] loaded;
      twr_slots_type       slots;
   } twr_plan_type;

endpackage

// ----- rtl/twr_plan.sv -----
module twr_plan
   import twr_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic [LAT_IN_W-1:0] cam_lat,
   input  logic [LON_IN_W-1:0] cam_lon,
   input  logic [SLOT_CNT-1:0] slot_ready,
   input  twr_slots_type       slots,
   output twr_plan_type        plan
);

   localparam int LAT_EXT_W = LAT_IN_W + TILE_LAT_W;
   localparam int LON_EXT_W = LON_IN_W + TILE_LON_W;

   logic [LAT_EXT_W-1:0] lat_ext;
   logic [LON_EXT_W-1:0] lon_ext;
   logic [TILE_LAT_W-1:0] lat_base, dl;
   logic [TILE_LON_W-1:0] lon_base, dn;
   logic lat_hi, lon_hi;
   logic [1:0] combo;
   logic [SLOT_CNT-1:0][TILE_LAT_W-1:0] need_lat;
   logic [SLOT_CNT-1:0][TILE_LON_W-1:0] need_lon;
   logic [SLOT_CNT-1:0] keep;
   twr_slots_type work;
   logic [SLOT_CNT-1:0] loaded;
   logic present, found;

   assign lat_ext  = {{TILE_LAT_W{cam_lat[LAT_IN_W-1]}}, cam_lat};
   assign lon_ext  = {{TILE_LON_W{cam_lon[LON_IN_W-1]}}, cam_lon};
   assign lat_base = lat_ext[FRAC_BITS +: TILE_LAT_W];
   assign lon_base = lon_ext[FRAC_BITS +: TILE_LON_W];
   assign lat_hi   = lat_ext[FRAC_BITS-1];
   assign lon_hi   = lon_ext[FRAC_BITS-1];
   assign dl       = lat_hi ? TILE_LAT_W'(1) : '1;
   assign dn       = lon_hi ? TILE_LON_W'(1) : '1;
   assign combo    = {~lat_hi, ~lon_hi};

   always_comb begin
      need_lat[0] = lat_base;
      need_lon[0] = lon_base;
      for (int i = 1; i < SLOT_CNT; i++) begin
         need_lat[i] = lat_base + (USE_LAT[combo][i-1] ? dl : '0);
         need_lon[i] = lon_base + (USE_LON[combo][i-1] ? dn : '0);
      end
   end

   // Drop slots whose tile is no longer in the window.
   always_comb begin
      for (int s = 0; s < SLOT_CNT; s++) begin
         keep[s] = 1'b0;
         for (int i = 0; i < SLOT_CNT; i++) begin
            if (slots.lat[s] == need_lat[i] && slots.lon[s] == need_lon[i]) begin
               keep[s] = slots.valid[s];
            end
         end
      end
   end

   // Place each missing tile, in list order, into the lowest free slot.
   always_comb begin
      work       = slots;
      work.valid = keep;
      loaded     = '0;
      present    = 1'b0;
      found      = 1'b0;
      for (int i = 0; i < SLOT_CNT; i++) begin
         present = 1'b0;
         for (int s = 0; s < SLOT_CNT; s++) begin
            if (work.valid[s] && work.lat[s] == need_lat[i] && work.lon[s] == need_lon[i]) begin
               present = 1'b1;
            end
         end
         found = present;
         for (int s = 0; s < SLOT_CNT; s++) begin
            if (!found && !work.valid[s]) begin
               work.valid[s] = 1'b1;
               work.lat[s]   = need_lat[i];
               work.lon[s]   = need_lon[i];
               work.pos[s]   = SLOT_W'(i);
               loaded[s]     = 1'b1;
               found         = 1'b1;
            end
         end
      end
   end

   assign plan.blocked = |(slots.valid & ~slot_ready);
   assign plan.loaded  = loaded;
   assign plan.slots   = work;

endmodule

// ----- rtl/tile_window_residency_core.sv -----
// Residency table for a two-by-two window of one-degree terrain tiles.
// Each request transaction carries the camera position and one load-done
// flag per slot; a request is first held in an input register, then the
// whole window update is worked out combinationally and written to the slot
// table once the previous batch has drained. If an occupied slot is still
// loading, one response transaction with action "blocked" comes back and
// the table stays as it was; otherwise four responses follow, one per slot
// in order 0..3, with tlast on slot 3. Responses are sent one per cycle,
// while rsp_tready is high, from the slot table itself. A new request is
// taken into the input register while the previous responses drain.
module tile_window_residency_core
   import twr_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // cam_lat[23:0], cam_lon[48:24], slot_ready[52:49], zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // slot_index[1:0], tile_lat[9:2], tile_lon[18:10],
                                    // tile_position[20:19], zeros
   output logic [1:0]  rsp_tuser,   // action[1:0]
   output logic        rsp_tlast
);

   // Input register
   logic                in_valid_ff, in_valid_in;
   logic [LAT_IN_W-1:0] cam_lat_ff;
   logic [LON_IN_W-1:0] cam_lon_ff;
   logic [SLOT_CNT-1:0] slot_ready_ff;

   // Slot table and response sequencing
   twr_slots_type       slots_ff, slots_in;
   logic                out_valid_ff, out_valid_in;
   logic                blocked_ff, blocked_in;
   logic [SLOT_CNT-1:0] loaded_ff, loaded_in;
   logic [SLOT_W-1:0]   cnt_ff, cnt_in;

   twr_plan_type plan;
   logic         take_req;
   logic         out_done;
   logic         batch_free;
   logic         go;

   twr_plan #(
      .FRAC_BITS (FRAC_BITS)
   ) u_plan (
      .cam_lat    (cam_lat_ff),
      .cam_lon    (cam_lon_ff),
      .slot_ready (slot_ready_ff),
      .slots      (slots_ff),
      .plan       (plan)
   );

   // The last response of a batch leaves this cycle.
   assign out_done   = out_valid_ff && rsp_tready && rsp_tlast;
   assign batch_free = !out_valid_ff || out_done;
   assign go         = in_valid_ff && batch_free;
   assign req_tready = !in_valid_ff || go;
   assign take_req   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      blocked_in   = blocked_ff;
      loaded_in    = loaded_ff;
      cnt_in       = cnt_ff;
      slots_in     = slots_ff;
      if (go) begin
         in_valid_in = 1'b0;
      end
      if (take_req) begin
         in_valid_in = 1'b1;
      end
      if (out_valid_ff && rsp_tready) begin
         cnt_in = cnt_ff + SLOT_W'(1);
         if (rsp_tlast) begin
            out_valid_in = 1'b0;
         end
      end
      // Commit the update and open a new response batch.
      if (go) begin
         out_valid_in = 1'b1;
         blocked_in   = plan.blocked;
         loaded_in    = plan.loaded;
         cnt_in       = '0;
         if (!plan.blocked) begin
            slots_in = plan.slots;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         blocked_ff   <= 1'b0;
         loaded_ff    <= '0;
         cnt_ff       <= '0;
         slots_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         blocked_ff   <= blocked_in;
         loaded_ff    <= loaded_in;
         cnt_ff       <= cnt_in;
         slots_ff     <= slots_in;
      end
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      if (take_req) begin
         cam_lat_ff    <= req_tdata[23:0];
         cam_lon_ff    <= req_tdata[48:24];
         slot_ready_ff <= req_tdata[52:49];
      end
   end

   // Response view of the current slot; a blocked answer reads as zeros.
   always_comb begin
      rsp_tvalid = out_valid_ff;
      rsp_tdata  = '0;
      if (blocked_ff) begin
         rsp_tuser = ACT_BLOCKED;
         rsp_tlast = 1'b1;
      end else begin
         rsp_tuser       = loaded_ff[cnt_ff] ? ACT_LOAD : ACT_KEPT;
         rsp_tlast       = (cnt_ff == SLOT_W'(SLOT_CNT - 1));
         rsp_tdata[1:0]  = cnt_ff;
         rsp_tdata[9:2]  = slots_ff.lat[cnt_ff];
         rsp_tdata[18:10] = slots_ff.lon[cnt_ff];
         rsp_tdata[20:19] = slots_ff.pos[cnt_ff];
      end
   end

   // A blocked answer is always a single, final response.
   a_blocked_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ACT_BLOCKED |-> rsp_tlast && rsp_tdata == '0)
      else $error("blocked response not final");

   // After an unblocked update every slot holds a tile.
   a_all_full : assert property (@(posedge clock) disable iff (reset)
      go && !plan.blocked |=> &slots_ff.valid)
      else $error("slot left empty after update");

   // A normal batch ends on the last slot.
   a_last_slot : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && rsp_tuser != ACT_BLOCKED |-> cnt_ff == SLOT_W'(SLOT_CNT - 1))
      else $error("batch ended early");

   // The table only changes when a new batch opens.
   a_table_hold : assert property (@(posedge clock) disable iff (reset)
      !go |=> $stable(slots_ff.valid))
      else $error("slot table changed without an update");

endmodule
